### rtl/core/textured_wall_column_renderer_defines.svh
// ----------------------------------------------------------------------------
// Textured wall column renderer assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef TEXTURED_WALL_COLUMN_RENDERER_DEFINES_SVH
`define TEXTURED_WALL_COLUMN_RENDERER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TWCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("twcr assertion failed");

`define TWCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("twcr assertion failed");

`else

`define TWCR_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define TWCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/twcr_pkg.sv
// ----------------------------------------------------------------------------
// twcr_pkg
// Shared constants, transaction types and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package twcr_pkg;

    localparam int SCREEN_W = 1024;
    localparam int SCREEN_H = 512;
    localparam int TEX_W    = 128;   // power of two
    localparam int TEX_H    = 128;   // power of two
    localparam int TILE     = 64;    // power of two

    localparam int FACE_W  = 2;
    localparam int COL_W   = $clog2(TEX_W);
    localparam int TROW_W  = $clog2(TEX_H);
    localparam int ADDR_W  = FACE_W + TROW_W + COL_W;
    localparam int DATA_W  = 32;

    localparam int ROW_W   = $clog2(SCREEN_H);
    localparam int END_W   = ROW_W + 1;
    localparam int H_W     = 16;
    localparam int OFF_W   = 16;

    localparam int ACC_W   = 24;
    localparam int FRAC_W  = 16;
    localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] CLAMP_ACC =
        ACC_W'((TEX_H - 1) << FRAC_W) | ACC_W'(1 << (FRAC_W - 1));
    localparam logic [ACC_W-1:0] DIVIDEND  = ACC_W'(TEX_H << FRAC_W);

    localparam int DIV_STEPS = ACC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // hit position: Q14 product shift, tile span in Q.8
    localparam int Q_SH    = 14;
    localparam int POS_W   = $clog2(TILE * 256);
    localparam int PROD_W  = Q_SH + POS_W;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         face;
        logic [6:0]         texel_col;
        logic [6:0]         texel_row;
        logic [31:0]        texel_color;
        logic [10:0]        screen_column;
        logic [15:0]        slice_height;
        logic [15:0]        player_px;
        logic [15:0]        player_py;
        logic [23:0]        ray_len;
        logic signed [15:0] ray_cosine;
        logic signed [15:0] ray_sine;
    } item_t;

    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [31:0] pixel_color;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic wr_en;
        logic start;
        logic step;
        logic div_run;
        logic acc_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic start_ok;
        logic step_hit;
        logic div_done;
    } sts_t;

endpackage

`default_nettype wire

### rtl/core/textured_wall_column_renderer.sv
// ----------------------------------------------------------------------------
// textured_wall_column_renderer
// Raycaster wall slice texturer: texel load, column start, per-pixel step.
// ----------------------------------------------------------------------------
// A load transaction writes one texel. A step transaction emits one pixel
// while the column has rows left; steps stream at one per cycle while the
// pixel port takes each result at once, since the 64K x 32 texture RAM read
// is registered and the next step is taken in the cycle its predecessor's
// pixel is loaded. A start transaction with a visible slice holds intake
// while a restoring divider computes the row step one quotient bit per cycle,
// then while the divider finishes and the first-row offset multiply runs.
// Invisible starts, idle steps and op 3 do not hold intake. The texture RAM
// is not cleared; read only texels that have been loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "textured_wall_column_renderer_defines.svh"

module textured_wall_column_renderer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire twcr_pkg::item_t  item,
    output logic                  pixel_valid,
    input  wire logic             pixel_ready,
    output twcr_pkg::pixel_t      pixel
);

    import twcr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    twcr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .op          (item.op),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    twcr_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd),
        .sts   (sts),
        .pixel (pixel)
    );

    `TWCR_ASSERT_NOW(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.wr_en, cmd.start, cmd.step, cmd.div_run, cmd.acc_load}))
    `TWCR_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, !pixel_valid || pixel_ready)
    `TWCR_ASSERT_NEXT(a_out_shown, clk, rst_n, cmd.out_load, pixel_valid)
    `TWCR_ASSERT_NEXT(a_div_stall, clk, rst_n, cmd.start && sts.start_ok, !item_ready)

endmodule

`default_nettype wire

### rtl/core/twcr_tex_ram.sv
// ----------------------------------------------------------------------------
// twcr_tex_ram
// Simple dual-port texture RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module twcr_tex_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/twcr_ctrl.sv
// ----------------------------------------------------------------------------
// twcr_ctrl
// Sequencer: transaction decode, divider wait, pixel fetch and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module twcr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire logic [1:0]       op,
    output logic                  pixel_valid,
    input  wire logic             pixel_ready,
    output twcr_pkg::cmd_t        cmd,
    input  wire twcr_pkg::sts_t   sts
);

    import twcr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_MUL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    always_comb
    begin
        out_free       = !out_valid_reg || pixel_ready;
        item_ready     = (state_reg == S_IDLE) || ((state_reg == S_FETCH) && out_free);
        accept         = item_valid && item_ready;

        cmd            = '0;
        cmd.wr_en      = accept && (op == OP_LOAD);
        cmd.start      = accept && (op == OP_START);
        cmd.step       = accept && (op == OP_STEP);

        state_next     = state_reg;
        out_valid_next = out_valid_reg && !pixel_ready;

        case (state_reg)
            S_IDLE, S_FETCH:
            begin
                if ((state_reg == S_FETCH) && out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                if (accept)
                begin
                    if (cmd.start && sts.start_ok)
                    begin
                        state_next = S_DIV;
                    end
                    else if (cmd.step && sts.step_hit)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.div_run = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.acc_load = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pixel_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/core/twcr_datapath.sv
// ----------------------------------------------------------------------------
// twcr_datapath
// Column span, texture column, row step divider, row accumulator, texture RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module twcr_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire twcr_pkg::item_t  item,
    input  wire twcr_pkg::cmd_t   cmd,
    output twcr_pkg::sts_t        sts,
    output twcr_pkg::pixel_t      pixel
);

    import twcr_pkg::*;

    localparam int SW    = H_W + 3;
    localparam int MUL_W = 25 + 16;
    localparam int OP_W  = OFF_W + ACC_W;

    // start decode
    logic [H_W-1:0]          h;
    logic signed [SW-1:0]    start_raw;
    logic signed [SW-1:0]    end_raw;
    logic signed [SW-1:0]    diff;
    logic signed [SW-1:0]    half;
    logic signed [SW-1:0]    off_raw;
    logic [ROW_W-1:0]        start_c;
    logic [END_W-1:0]        end_c;
    logic [OFF_W-1:0]        off_c;
    logic                    scol_ok;
    logic signed [15:0]      mul_b;
    logic signed [MUL_W-1:0] prod_full;

    // column state
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_reg;
    logic [15:0]             base_reg;
    logic [OFF_W-1:0]        off_reg;
    logic [H_W-1:0]          h_reg;
    logic [ACC_W-1:0]        dvd_reg;
    logic [H_W-1:0]          rem_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [ROW_W-1:0]        cur_row_reg;
    logic [END_W-1:0]        end_row_reg;
    logic [COL_W-1:0]        tex_col_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        step_reg;
    logic [9:0]              held_col_reg;
    logic [FACE_W-1:0]       held_face_reg;
    logic                    active_reg;

    // divider
    logic [H_W:0]            rem_shift;
    logic                    rem_ge;
    logic [H_W:0]            rem_sub;

    // texture column
    logic [PROD_W-1:0]       p_low;
    logic [POS_W-1:0]        pos_r;
    logic [POS_W+COL_W-1:0]  scaled;
    logic [COL_W-1:0]        tex_col_calc;

    // offset multiply
    logic [OP_W-1:0]         acc_prod;
    logic [ACC_W-1:0]        acc_init;

    // step
    logic [7:0]              row_raw;
    logic                    clamp;
    logic [ACC_W-1:0]        acc_c;
    logic [TROW_W-1:0]       row;
    logic [ACC_W:0]          acc_sum;
    logic [END_W-1:0]        cur_inc;
    logic                    rd_en;
    logic [ADDR_W-1:0]       raddr;
    logic [DATA_W-1:0]       rdata;

    // pending pixel
    logic [9:0]              pend_x_reg;
    logic [8:0]              pend_y_reg;
    logic                    pend_last_reg;
    pixel_t                  pixel_reg;

    always_comb
    begin
        h         = item.slice_height;
        scol_ok   = 12'(item.screen_column) < 12'(SCREEN_W);
        start_raw = $signed(SW'(SCREEN_H / 2)) - $signed(SW'(h >> 1));
        end_raw   = start_raw + $signed(SW'(h));
        start_c   = start_raw[SW-1] ? '0 : start_raw[ROW_W-1:0];
        end_c     = (end_raw >= $signed(SW'(SCREEN_H))) ? END_W'(SCREEN_H)
                                                        : end_raw[END_W-1:0];
        diff      = $signed(SW'(SCREEN_H)) - $signed(SW'(h));
        half      = diff[SW-1] ? -((-diff) >>> 1) : (diff >>> 1);
        off_raw   = $signed(SW'(start_c)) - half;
        off_c     = off_raw[SW-1] ? '0 : off_raw[OFF_W-1:0];
        mul_b     = item.face[1] ? item.ray_sine : item.ray_cosine;
        prod_full = $signed({1'b0, item.ray_len}) * mul_b;

        sts.start_ok = scol_ok && (h != '0) && ({1'b0, start_c} < end_c);
        sts.step_hit = active_reg && ({1'b0, cur_row_reg} < end_row_reg);
        sts.div_done = (cnt_reg == '0);
    end

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[ACC_W-1]};
        rem_ge    = rem_shift >= {1'b0, h_reg};
        rem_sub   = rem_shift - {1'b0, h_reg};
    end

    // hit position mod tile, scaled to texture column
    always_comb
    begin
        p_low        = neg_reg ? PROD_W'(-prod_reg) : prod_reg;
        pos_r        = POS_W'({base_reg, 8'h00}) + p_low[PROD_W-1:Q_SH];
        scaled       = pos_r * COL_W'(TEX_W - 1);
        tex_col_calc = scaled[POS_W+COL_W-1:POS_W];
        acc_prod     = off_reg * dvd_reg;
        acc_init     = (acc_prod[OP_W-1:ACC_W] != '0) ? ACC_MAX : acc_prod[ACC_W-1:0];
    end

    always_comb
    begin
        row_raw = acc_reg[ACC_W-1:FRAC_W];
        clamp   = 9'(row_raw) >= 9'(TEX_H);
        acc_c   = clamp ? CLAMP_ACC : acc_reg;
        row     = clamp ? TROW_W'(TEX_H - 1) : row_raw[TROW_W-1:0];
        acc_sum = {1'b0, acc_c} + {1'b0, step_reg};
        cur_inc = END_W'(cur_row_reg) + END_W'(1);
        rd_en   = cmd.step && sts.step_hit;
        raddr   = {held_face_reg, row, tex_col_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                active_reg <= 1'b0;
                if (sts.start_ok)
                begin
                    cnt_reg <= CNT_W'(DIV_STEPS);
                end
            end
            else if (cmd.div_run)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else if (cmd.acc_load)
            begin
                active_reg <= 1'b1;
            end
            else if (cmd.step && active_reg)
            begin
                if (!sts.step_hit || (cur_inc >= end_row_reg))
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && sts.start_ok)
        begin
            prod_reg      <= prod_full[PROD_W-1:0];
            neg_reg       <= item.face[1];
            base_reg      <= item.face[1] ? item.player_py : item.player_px;
            off_reg       <= off_c;
            h_reg         <= h;
            dvd_reg       <= DIVIDEND;
            rem_reg       <= '0;
            cur_row_reg   <= start_c;
            end_row_reg   <= end_c;
            held_col_reg  <= item.screen_column[9:0];
            held_face_reg <= item.face;
        end
        else if (cmd.div_run)
        begin
            rem_reg <= rem_ge ? rem_sub[H_W-1:0] : rem_shift[H_W-1:0];
            dvd_reg <= {dvd_reg[ACC_W-2:0], rem_ge};
        end
        else if (cmd.acc_load)
        begin
            acc_reg     <= acc_init;
            step_reg    <= dvd_reg;
            tex_col_reg <= tex_col_calc;
        end
        else if (rd_en)
        begin
            acc_reg       <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
            cur_row_reg   <= cur_inc[ROW_W-1:0];
            pend_x_reg    <= held_col_reg;
            pend_y_reg    <= 9'(cur_row_reg);
            pend_last_reg <= (cur_inc == end_row_reg);
        end

        if (cmd.out_load)
        begin
            pixel_reg.pixel_x     <= pend_x_reg;
            pixel_reg.pixel_y     <= pend_y_reg;
            pixel_reg.pixel_color <= rdata;
            pixel_reg.last_pixel  <= pend_last_reg;
        end
    end

    twcr_tex_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_tex_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr ({item.face, item.texel_row[TROW_W-1:0], item.texel_col[COL_W-1:0]}),
        .wdata (item.texel_color),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign pixel = pixel_reg;

endmodule

`default_nettype wire
